### rtl/assert_macros.svh
// assertion macros used by the sequencer top level
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tvms_pkg.sv
// constants, codes and the note period table of the three voice sequencer
// no dependencies; imported by the sequencer top level
`timescale 1ns / 1ps
`default_nettype none

package tvms_pkg;

  // song store size default
  localparam int unsigned SONG_DEPTH_DEF = 1024;

  // item commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // register indexes
  localparam int unsigned CFG_IDX_W   = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OCT_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCT_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCT_WAVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_PER   = 3'd4;
  localparam int unsigned CFG_DATA_W  = 8;

  // register reset values
  localparam logic [3:0] OCT_RST         = 4'd4;
  localparam logic [7:0] ROW_PERIOD_RST  = 8'd130;
  localparam logic [7:0] FADE_PERIOD_RST = 8'd3;

  // song and voice constants
  localparam logic [7:0]  END_MARK      = 8'hFF;
  localparam logic [3:0]  FADE_STEP_TOP = 4'd8;
  localparam int unsigned NOTE_COUNT    = 72;
  localparam int unsigned PERIOD_W      = 11;

  localparam logic [PERIOD_W-1:0] PERIOD_TABLE [NOTE_COUNT] = '{
    11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
    11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
    11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
    11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
    11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
    11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
    11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
    11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
    11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
    11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
    11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
    11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
  };

  // period of a table index, silence past the end of the table
  function automatic logic [PERIOD_W-1:0] period_lookup(input logic [7:0] idx);
    logic [PERIOD_W-1:0] res;
    res = '0;
    if (idx < 8'(NOTE_COUNT)) begin
      res = PERIOD_TABLE[idx[6:0]];
    end
    return res;
  endfunction

  // wave amplitude nibble of a fade step
  function automatic logic [3:0] wave_level_of(input logic [3:0] step);
    logic [4:0] dbl;
    dbl = {step, 1'b0} - 5'd1;
    return (step == 4'd0) ? 4'd0 : dbl[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tvms_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tvms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/three_voice_music_sequencer_top.sv
// Three voice music sequencer, top level.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer: cmd_i 1 writes
// load_data_i to the song store at load_addr_i, cmd_i 0 is a tick of playback time.
// Only ticks give a result, on the output channel (out_valid_o / out_stall_i).
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), to be used while
// idle; the block itself does not enforce this. A song write is taken at its transfer and
// the block is ready again at once. A tick that does not play a row goes from idle through
// the done state to the output register. A tick that plays a row reads the header, then
// works one voice per cycle through a single note subtract and period table unit, reading
// a note byte only for a voice that is on with a new note. When the header byte is the end
// mark, the read pointer first jumps back to address 0, whose byte is then the header. The
// registered song memory read port and the shared note unit set this order of steps; one
// item is worked on at a time. The next item is taken in the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds it there while the
// next item is taken, and the sequencer waits at its last step until the register frees.
// Reset clears the registers to their defaults, the read pointer, row divider, fade state
// and routing; the song store holds nothing defined until written, and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module three_voice_music_sequencer_top #(
  parameter int unsigned SONG_DEPTH = tvms_pkg::SONG_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [tvms_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tvms_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             cmd_i,
  input  wire logic [9:0]                       load_addr_i,
  input  wire logic [7:0]                       load_data_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  row_played_o,
  output logic                                  pulse_a_routed_o,
  output logic                                  pulse_a_trigger_o,
  output logic [tvms_pkg::PERIOD_W-1:0]         pulse_a_period_o,
  output logic                                  pulse_b_routed_o,
  output logic                                  pulse_b_trigger_o,
  output logic [tvms_pkg::PERIOD_W-1:0]         pulse_b_period_o,
  output logic                                  wave_routed_o,
  output logic                                  wave_trigger_o,
  output logic [tvms_pkg::PERIOD_W-1:0]         wave_period_o,
  output logic [3:0]                            wave_level_o,
  output logic                                  wave_reload_o
);

  import tvms_pkg::*;

  localparam int unsigned AW   = $clog2(SONG_DEPTH);
  localparam int unsigned CMPW = 17;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HDR   = 3'd1;
  localparam logic [2:0] S_HDR0  = 3'd2;
  localparam logic [2:0] S_VOICE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // voice codes
  localparam logic [1:0] VOICE_A    = 2'd0;
  localparam logic [1:0] VOICE_B    = 2'd1;
  localparam logic [1:0] VOICE_WAVE = 2'd2;

  typedef struct packed {
    logic                row;
    logic                routed_a;
    logic                trig_a;
    logic [PERIOD_W-1:0] per_a;
    logic                routed_b;
    logic                trig_b;
    logic [PERIOD_W-1:0] per_b;
    logic                routed_w;
    logic                trig_w;
    logic [PERIOD_W-1:0] per_w;
    logic [3:0]          level;
    logic                reload;
  } result_t;

  // configuration registers
  logic [3:0] oct_a_q, oct_b_q, oct_w_q;
  logic [7:0] row_period_q, fade_period_q;

  // sequencer and song state
  logic [2:0]          state_q, state_d;
  logic [1:0]          voice_q, voice_d;
  logic [7:0]          hdr_q, hdr_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d, ptr_inc;
  logic [7:0]          row_cd_q, row_cd_d;
  logic [7:0]          fade_cd_q, fade_cd_d;
  logic [3:0]          fade_step_q, fade_step_d;
  logic [PERIOD_W-1:0] wave_hold_q, wave_hold_d;
  logic [2:0]          routed_q, routed_d;

  // per-tick working results
  logic                row_q, row_d;
  logic                trig_a_q, trig_a_d, trig_b_q, trig_b_d, trig_w_q, trig_w_d;
  logic [PERIOD_W-1:0] per_a_q, per_a_d, per_b_q, per_b_d;
  logic                reload_q, reload_d;

  // output register
  logic    out_valid_q, out_valid_d;
  logic    out_load;
  result_t out_q, res;

  // song memory
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_rdata;
  logic [CMPW-1:0] addr_ext;
  logic            addr_in_range;

  // shared note unit
  logic [3:0]          nu_oct;
  logic [7:0]          nu_off;
  logic [8:0]          nu_diff;
  logic [PERIOD_W-1:0] nu_period;
  logic                v_on, v_new;

  logic in_xfer;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // song write address and range check
  assign addr_ext      = CMPW'(load_addr_i);
  assign addr_in_range = addr_ext < CMPW'(SONG_DEPTH);
  assign ram_waddr     = addr_ext[AW-1:0];
  assign ram_we        = in_xfer && (cmd_i == CMD_LOAD) && addr_in_range;

  assign ptr_inc = (rd_ptr_q == AW'(SONG_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);

  // read address follows the next pointer, so the data always matches rd_ptr_q
  tvms_ram #(
    .WIDTH (8),
    .DEPTH (SONG_DEPTH)
  ) u_song_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (load_data_i),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  // voice fields of the header and octave select
  always_comb begin
    v_on   = 1'b0;
    v_new  = 1'b0;
    nu_oct = oct_a_q;
    unique case (voice_q)
      VOICE_A: begin
        v_on   = hdr_q[4];
        v_new  = hdr_q[5];
        nu_oct = oct_a_q;
      end
      VOICE_B: begin
        v_on   = hdr_q[2];
        v_new  = hdr_q[3];
        nu_oct = oct_b_q;
      end
      VOICE_WAVE: begin
        v_on   = hdr_q[0];
        v_new  = hdr_q[1];
        nu_oct = oct_w_q;
      end
      default: begin
        v_on   = 1'b0;
        v_new  = 1'b0;
        nu_oct = oct_a_q;
      end
    endcase
  end

  // note unit: subtract twelve notes per octave and look the period up
  assign nu_off    = {nu_oct, 3'b000} + {2'b00, nu_oct, 2'b00};
  assign nu_diff   = {1'b0, ram_rdata} - {1'b0, nu_off};
  assign nu_period = nu_diff[8] ? '0 : period_lookup(nu_diff[7:0]);

  // sequencer
  always_comb begin
    state_d     = state_q;
    voice_d     = voice_q;
    hdr_d       = hdr_q;
    rd_ptr_d    = rd_ptr_q;
    row_cd_d    = row_cd_q;
    fade_cd_d   = fade_cd_q;
    fade_step_d = fade_step_q;
    wave_hold_d = wave_hold_q;
    routed_d    = routed_q;
    row_d       = row_q;
    trig_a_d    = trig_a_q;
    trig_b_d    = trig_b_q;
    trig_w_d    = trig_w_q;
    per_a_d     = per_a_q;
    per_b_d     = per_b_q;
    reload_d    = reload_q;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (cmd_i == CMD_TICK)) begin
          trig_a_d = 1'b0;
          trig_b_d = 1'b0;
          trig_w_d = 1'b0;
          per_a_d  = '0;
          per_b_d  = '0;
          reload_d = 1'b0;
          if (row_cd_q == 8'd0) begin
            row_d    = 1'b1;
            row_cd_d = row_period_q;
            state_d  = S_HDR;
          end else begin
            row_d    = 1'b0;
            row_cd_d = row_cd_q - 8'd1;
            state_d  = S_DONE;
          end
        end
      end
      S_HDR: begin
        if (ram_rdata == END_MARK) begin
          rd_ptr_d = '0;
          state_d  = S_HDR0;
        end else begin
          hdr_d    = ram_rdata;
          rd_ptr_d = ptr_inc;
          voice_d  = VOICE_A;
          state_d  = S_VOICE;
        end
      end
      S_HDR0: begin
        // byte at address 0 is the header even when it is the end mark
        hdr_d    = ram_rdata;
        rd_ptr_d = ptr_inc;
        voice_d  = VOICE_A;
        state_d  = S_VOICE;
      end
      S_VOICE: begin
        if (!v_on) begin
          routed_d[voice_q] = 1'b0;
        end else if (v_new) begin
          routed_d[voice_q] = 1'b1;
          rd_ptr_d          = ptr_inc;
        end
        unique case (voice_q)
          VOICE_A: begin
            if (v_on && v_new) begin
              per_a_d  = nu_period;
              trig_a_d = 1'b1;
            end
            voice_d = VOICE_B;
          end
          VOICE_B: begin
            if (v_on && v_new) begin
              per_b_d  = nu_period;
              trig_b_d = 1'b1;
            end
            voice_d = VOICE_WAVE;
          end
          VOICE_WAVE: begin
            if (v_on && v_new) begin
              fade_cd_d   = fade_period_q;
              fade_step_d = FADE_STEP_TOP;
              wave_hold_d = nu_period;
              trig_w_d    = 1'b1;
              reload_d    = 1'b1;
            end else if (v_on) begin
              // held wave note fades on its own countdown
              if (fade_cd_q == 8'd0) begin
                if (fade_step_q != 4'd0) begin
                  fade_step_d = fade_step_q - 4'd1;
                  trig_w_d    = 1'b1;
                  reload_d    = 1'b1;
                end
                fade_cd_d = fade_period_q;
              end else begin
                fade_cd_d = fade_cd_q - 8'd1;
              end
            end
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    res.row      = row_q;
    res.routed_a = routed_q[0];
    res.trig_a   = trig_a_q;
    res.per_a    = per_a_q;
    res.routed_b = routed_q[1];
    res.trig_b   = trig_b_q;
    res.per_b    = per_b_q;
    res.routed_w = routed_q[2];
    res.trig_w   = trig_w_q;
    res.per_w    = wave_hold_q;
    res.level    = wave_level_of(fade_step_q);
    res.reload   = reload_q;
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_a_q       <= OCT_RST;
      oct_b_q       <= OCT_RST;
      oct_w_q       <= OCT_RST;
      row_period_q  <= ROW_PERIOD_RST;
      fade_period_q <= FADE_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OCT_A:      oct_a_q       <= cfg_data_i[3:0];
        REG_OCT_B:      oct_b_q       <= cfg_data_i[3:0];
        REG_OCT_WAVE:   oct_w_q       <= cfg_data_i[3:0];
        REG_ROW_PERIOD: row_period_q  <= cfg_data_i;
        REG_FADE_PER:   fade_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and song state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      voice_q     <= VOICE_A;
      rd_ptr_q    <= '0;
      row_cd_q    <= '0;
      fade_cd_q   <= FADE_PERIOD_RST;
      fade_step_q <= FADE_STEP_TOP;
      wave_hold_q <= '0;
      routed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      voice_q     <= voice_d;
      rd_ptr_q    <= rd_ptr_d;
      row_cd_q    <= row_cd_d;
      fade_cd_q   <= fade_cd_d;
      fade_step_q <= fade_step_d;
      wave_hold_q <= wave_hold_d;
      routed_q    <= routed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload, no reset needed
  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    row_q    <= row_d;
    trig_a_q <= trig_a_d;
    trig_b_q <= trig_b_d;
    trig_w_q <= trig_w_d;
    per_a_q  <= per_a_d;
    per_b_q  <= per_b_d;
    reload_q <= reload_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign row_played_o      = out_q.row;
  assign pulse_a_routed_o  = out_q.routed_a;
  assign pulse_a_trigger_o = out_q.trig_a;
  assign pulse_a_period_o  = out_q.per_a;
  assign pulse_b_routed_o  = out_q.routed_b;
  assign pulse_b_trigger_o = out_q.trig_b;
  assign pulse_b_period_o  = out_q.per_b;
  assign wave_routed_o     = out_q.routed_w;
  assign wave_trigger_o    = out_q.trig_w;
  assign wave_period_o     = out_q.per_w;
  assign wave_level_o      = out_q.level;
  assign wave_reload_o     = out_q.reload;

  // output side terms for the checks
  logic out_trig_any, out_trig_a, out_quiet_b;
  assign out_trig_any = out_valid_o && (pulse_a_trigger_o || pulse_b_trigger_o || wave_trigger_o);
  assign out_trig_a   = out_valid_o && pulse_a_trigger_o;
  assign out_quiet_b  = out_valid_o && !pulse_b_trigger_o;

  // checks
  `ASSERT_IMPL(a_ptr_range, 1'b1, rd_ptr_q <= AW'(SONG_DEPTH - 1), "read pointer past song end")
  `ASSERT_IMPL(a_fade_top, 1'b1, fade_step_q <= FADE_STEP_TOP, "fade step above top")
  `ASSERT_IMPL(a_trig_row, out_trig_any, row_played_o, "voice triggered without a row")
  `ASSERT_IMPL(a_trig_routed, out_trig_a, pulse_a_routed_o, "voice one triggered, not routed")
  `ASSERT_IMPL(a_idle_period, out_quiet_b, pulse_b_period_o == '0, "voice two period, no trigger")

endmodule

`default_nettype wire
